>>> hw/rtl/spk_pkg.sv
// Shared types, constants and helper functions for the 128-bit spooky hash block.
// No dependencies; the files that use it refer to it by scoped names.
package spk_pkg;

  localparam int unsigned LANES    = 12;
  localparam int unsigned BUF_AW   = 5;
  localparam int unsigned BUF_DEPTH = 24;

  localparam logic [63:0] SC_CONST    = 64'hDEADBEEFDEADBEEF;
  localparam logic [7:0]  SHORT_LIMIT = 8'd192;
  localparam logic [3:0]  LAST_STEP   = 4'd11;
  localparam logic [3:0]  QEND_LAST   = 4'd10;
  localparam logic [3:0]  FULL_WORD   = 4'd8;

  localparam logic [7:0] REG_SEED_FIRST  = 8'd0;
  localparam logic [7:0] REG_SEED_SECOND = 8'd1;

  localparam logic [5:0] MIX_ROT [12] = '{6'd11, 6'd32, 6'd43, 6'd31, 6'd17, 6'd28,
                                          6'd39, 6'd57, 6'd55, 6'd54, 6'd22, 6'd46};
  localparam logic [5:0] ENDR_ROT [12] = '{6'd44, 6'd15, 6'd34, 6'd21, 6'd38, 6'd33,
                                           6'd10, 6'd13, 6'd38, 6'd53, 6'd42, 6'd54};
  localparam logic [5:0] QMIX_ROT [12] = '{6'd50, 6'd52, 6'd30, 6'd41, 6'd54, 6'd48,
                                           6'd38, 6'd37, 6'd62, 6'd34, 6'd5, 6'd36};
  localparam logic [5:0] QEND_ROT [11] = '{6'd15, 6'd52, 6'd26, 6'd51, 6'd28, 6'd9,
                                           6'd47, 6'd54, 6'd32, 6'd25, 6'd63};

  typedef logic [LANES-1:0][63:0] spk_lanes_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LMIX,
    OP_ABSORB,
    OP_ENDR,
    OP_QMIX,
    OP_QEND,
    OP_QADD
  } spk_op_t;

  typedef struct packed {
    spk_op_t    op;
    logic [3:0] step;
    logic [1:0] pos;
  } spk_ctl_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] k);
    return (x << k) | (x >> (7'd64 - {1'b0, k}));
  endfunction

  function automatic logic [63:0] low_bytes(input logic [63:0] w, input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < n) m[b*8 +: 8] = 8'hFF;
    end
    return w & m;
  endfunction

endpackage

>>> hw/rtl/spk_ifs.sv
// Handshake channel interfaces: message words in, hash out, seed register writes.
// Depends on nothing.
interface spk_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  bytes_valid;
  logic        last_word;
  modport source (output valid, data_word, bytes_valid, last_word, input ready);
  modport sink   (input valid, data_word, bytes_valid, last_word, output ready);
endinterface

interface spk_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_first;
  logic [63:0] hash_second;
  modport source (output valid, hash_first, hash_second, input ready);
  modport sink   (input valid, hash_first, hash_second, output ready);
endinterface

interface spk_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/spooky_hash_128_stream.sv
// Operation: a word that fills a 96-byte block starts a block mix (prime read, then 12 mix
//   steps); the 192-byte switch to the long path mixes both buffered blocks in turn.
// End of message: long path absorbs the padded remainder, then three end rounds of 12 steps;
//   short path per 32-byte block does 4 word loads and 12 quad steps, then tail and 11 end steps.
// Throughput: one message word per cycle while idle, between block boundaries; the single shared
//   mixing unit and the one read port of the message store hold input off while they are busy.
// Reset (rst_n, synchronous, active low) clears control state and the seeds; no clearing pass.
module spooky_hash_128_stream (
  input  logic      clk,
  input  logic      rst_n,
  spk_in_if.sink    in_chan,
  spk_out_if.source out_chan,
  spk_cfg_if.sink   cfg_chan
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_LPRE,     // prime read of first block word
    S_LMIX,     // 12-step lane mix
    S_APRE,
    S_ABS,      // absorb padded remainder
    S_ENDR,     // three end rounds
    S_SH_CHK,
    S_SH_RD,
    S_SH_ADD,
    S_SH_QMIX,
    S_SH_TAIL,
    S_SH_TC2,
    S_SH_TC3,
    S_SH_TRD,
    S_SH_TADD,
    S_SH_QEND,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [1:0]  rnd_r, rnd_nxt;
  spk_pkg::spk_lanes_t lanes_r, lanes_nxt, unit_lanes;
  logic [63:0] seed1_r, seed1_nxt, seed2_r, seed2_nxt;
  logic [7:0]  bs_r, bs_nxt;          // bytes seen (short: total, long: in block)
  logic        long_r, long_nxt;
  logic [3:0]  bwi_r, bwi_nxt;        // word index in current long block
  logic        pend2_r, pend2_nxt;    // upper-half mix still due (long path start)
  logic        hi_r, hi_nxt;          // current mix reads words 12..23
  logic        fin_r, fin_nxt;        // finish message after the mix
  logic [4:0]  p_r, p_nxt;            // short path word pointer
  logic [4:0]  rem_r, rem_nxt;
  logic [2:0]  bcnt_r, bcnt_nxt;
  logic        half_r, half_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic        tsec_r, tsec_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] hash1_r, hash1_nxt, hash2_r, hash2_nxt;

  spk_pkg::spk_ctl_t ctl;
  logic [63:0] unit_data;
  logic        wr_en;
  logic [spk_pkg::BUF_AW-1:0] wr_addr, rd_addr;
  logic [63:0] wr_data, rd_data;

  logic        in_fire;
  logic [3:0]  n_eff;
  logic [63:0] w_in;
  logic [7:0]  bs_sum, bs_new;
  logic [3:0]  rd_idx;
  logic [63:0] blk_word;
  logic [3:0]  tail_n;

  spk_msg_buf u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  spk_round_unit u_unit (
    .ctl       (ctl),
    .lanes     (lanes_r),
    .data      (unit_data),
    .lanes_out (unit_lanes)
  );

  assign in_chan.ready      = (state_r == S_IDLE);
  assign cfg_chan.ready     = 1'b1;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.hash_first  = hash1_r;
  assign out_chan.hash_second = hash2_r;

  assign in_fire = in_chan.valid && (state_r == S_IDLE);
  // non-final words always count 8 bytes; a final word saturates at 8
  assign n_eff  = !in_chan.last_word ? spk_pkg::FULL_WORD :
                  (in_chan.bytes_valid > spk_pkg::FULL_WORD) ? spk_pkg::FULL_WORD :
                  in_chan.bytes_valid;
  assign w_in   = spk_pkg::low_bytes(in_chan.data_word, n_eff);
  assign bs_sum = bs_r + {4'd0, n_eff};
  assign bs_new = (n_eff != 4'd0) ? bs_sum : bs_r;

  // prefetch next block word; hold at the last one
  assign rd_idx = (step_r == spk_pkg::LAST_STEP) ? step_r : step_r + 4'd1;

  // padded remainder word: zero past the fill, byte count in the top byte of word 11
  always_comb begin
    blk_word = (step_r < bwi_r) ? rd_data : 64'd0;
    if (step_r == spk_pkg::LAST_STEP) blk_word[63:56] = bs_r;
  end

  assign tail_n = rem_r[3] ? spk_pkg::FULL_WORD : rem_r[3:0];

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rnd_nxt   = rnd_r;
    seed1_nxt = seed1_r;
    seed2_nxt = seed2_r;
    bs_nxt    = bs_r;
    long_nxt  = long_r;
    bwi_nxt   = bwi_r;
    pend2_nxt = pend2_r;
    hi_nxt    = hi_r;
    fin_nxt   = fin_r;
    p_nxt     = p_r;
    rem_nxt   = rem_r;
    bcnt_nxt  = bcnt_r;
    half_nxt  = half_r;
    sub_nxt   = sub_r;
    tsec_nxt  = tsec_r;
    out_valid_nxt = out_valid_r;
    hash1_nxt = hash1_r;
    hash2_nxt = hash2_r;
    ctl.op    = spk_pkg::OP_HOLD;
    ctl.step  = step_r;
    ctl.pos   = 2'd0;
    unit_data = 64'd0;
    wr_en     = 1'b0;
    wr_addr   = bs_r[7:3];
    wr_data   = w_in;
    rd_addr   = '0;
    lanes_nxt = unit_lanes;

    if (cfg_chan.valid) begin
      if (cfg_chan.index == spk_pkg::REG_SEED_FIRST)  seed1_nxt = cfg_chan.data;
      if (cfg_chan.index == spk_pkg::REG_SEED_SECOND) seed2_nxt = cfg_chan.data;
    end

    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!long_r) begin
            wr_en   = (n_eff != 4'd0);
            wr_addr = bs_r[7:3];
            bs_nxt  = bs_new;
            if (bs_new >= spk_pkg::SHORT_LIMIT) begin
              // switch to the 12-lane path: seed lanes, then mix both buffered blocks
              for (int i = 0; i < 12; i++) begin
                lanes_nxt[i] = (i % 3 == 0) ? seed1_r :
                               (i % 3 == 1) ? seed2_r : spk_pkg::SC_CONST;
              end
              long_nxt  = 1'b1;
              bs_nxt    = 8'd0;
              bwi_nxt   = 4'd0;
              pend2_nxt = 1'b1;
              hi_nxt    = 1'b0;
              fin_nxt   = in_chan.last_word;
              step_nxt  = 4'd0;
              state_nxt = S_LPRE;
            end else if (in_chan.last_word) begin
              lanes_nxt[0] = seed1_r;
              lanes_nxt[1] = seed2_r;
              lanes_nxt[2] = spk_pkg::SC_CONST;
              lanes_nxt[3] = spk_pkg::SC_CONST;
              rem_nxt   = bs_new[4:0];
              bcnt_nxt  = bs_new[7:5];
              p_nxt     = 5'd0;
              tsec_nxt  = 1'b0;
              state_nxt = S_SH_CHK;
            end
          end else begin
            if (n_eff != 4'd0) begin
              wr_en   = 1'b1;
              wr_addr = {1'b0, bwi_r};
              bwi_nxt = bwi_r + 4'd1;
              bs_nxt  = bs_sum;
              if (bwi_r == spk_pkg::LAST_STEP && n_eff == spk_pkg::FULL_WORD) begin
                bwi_nxt   = 4'd0;
                bs_nxt    = 8'd0;
                pend2_nxt = 1'b0;
                hi_nxt    = 1'b0;
                fin_nxt   = in_chan.last_word;
                step_nxt  = 4'd0;
                state_nxt = S_LPRE;
              end else if (in_chan.last_word) begin
                state_nxt = S_APRE;
              end
            end else if (in_chan.last_word) begin
              state_nxt = S_APRE;
            end
          end
        end
      end

      S_LPRE: begin
        rd_addr   = hi_r ? 5'd12 : 5'd0;
        step_nxt  = 4'd0;
        state_nxt = S_LMIX;
      end

      S_LMIX: begin
        ctl.op    = spk_pkg::OP_LMIX;
        unit_data = rd_data;
        rd_addr   = (hi_r ? 5'd12 : 5'd0) + {1'b0, rd_idx};
        step_nxt  = step_r + 4'd1;
        if (step_r == spk_pkg::LAST_STEP) begin
          step_nxt = 4'd0;
          if (pend2_r) begin
            pend2_nxt = 1'b0;
            hi_nxt    = 1'b1;
            state_nxt = S_LPRE;
          end else begin
            hi_nxt    = 1'b0;
            state_nxt = fin_r ? S_APRE : S_IDLE;
          end
        end
      end

      S_APRE: begin
        rd_addr   = 5'd0;
        step_nxt  = 4'd0;
        state_nxt = S_ABS;
      end

      S_ABS: begin
        ctl.op    = spk_pkg::OP_ABSORB;
        unit_data = blk_word;
        rd_addr   = {1'b0, rd_idx};
        step_nxt  = step_r + 4'd1;
        if (step_r == spk_pkg::LAST_STEP) begin
          step_nxt  = 4'd0;
          rnd_nxt   = 2'd0;
          state_nxt = S_ENDR;
        end
      end

      S_ENDR: begin
        ctl.op   = spk_pkg::OP_ENDR;
        step_nxt = step_r + 4'd1;
        if (step_r == spk_pkg::LAST_STEP) begin
          step_nxt = 4'd0;
          rnd_nxt  = rnd_r + 2'd1;
          if (rnd_r == 2'd2) state_nxt = S_DONE;
        end
      end

      S_SH_CHK: begin
        if (bs_r > 8'd15 && bcnt_r != 3'd0) begin
          half_nxt  = 1'b0;
          sub_nxt   = 2'd0;
          state_nxt = S_SH_RD;
        end else if (bs_r > 8'd15 && rem_r[4]) begin
          half_nxt  = 1'b1;
          sub_nxt   = 2'd0;
          state_nxt = S_SH_RD;
        end else begin
          state_nxt = S_SH_TAIL;
        end
      end

      S_SH_RD: begin
        rd_addr   = p_r;
        state_nxt = S_SH_ADD;
      end

      S_SH_ADD: begin
        // word order within a 32-byte block goes to lanes c, d, a, b
        ctl.op    = spk_pkg::OP_QADD;
        ctl.pos   = sub_r ^ 2'd2;
        unit_data = rd_data;
        p_nxt     = p_r + 5'd1;
        if (sub_r == 2'd1) begin
          step_nxt  = 4'd0;
          state_nxt = S_SH_QMIX;
        end else if (sub_r == 2'd3) begin
          bcnt_nxt  = bcnt_r - 3'd1;
          state_nxt = S_SH_CHK;
        end else begin
          sub_nxt   = sub_r + 2'd1;
          state_nxt = S_SH_RD;
        end
      end

      S_SH_QMIX: begin
        ctl.op   = spk_pkg::OP_QMIX;
        step_nxt = step_r + 4'd1;
        if (step_r == spk_pkg::LAST_STEP) begin
          step_nxt = 4'd0;
          if (half_r) begin
            rem_nxt   = {1'b0, rem_r[3:0]};
            state_nxt = S_SH_CHK;
          end else begin
            sub_nxt   = 2'd2;
            state_nxt = S_SH_RD;
          end
        end
      end

      S_SH_TAIL: begin
        // length into the top byte of lane d
        ctl.op    = spk_pkg::OP_QADD;
        ctl.pos   = 2'd3;
        unit_data = {bs_r, 56'd0};
        state_nxt = (rem_r == 5'd0) ? S_SH_TC2 : S_SH_TRD;
      end

      S_SH_TC2: begin
        ctl.op    = spk_pkg::OP_QADD;
        ctl.pos   = 2'd2;
        unit_data = spk_pkg::SC_CONST;
        state_nxt = S_SH_TC3;
      end

      S_SH_TC3: begin
        ctl.op    = spk_pkg::OP_QADD;
        ctl.pos   = 2'd3;
        unit_data = spk_pkg::SC_CONST;
        step_nxt  = 4'd0;
        state_nxt = S_SH_QEND;
      end

      S_SH_TRD: begin
        rd_addr   = p_r;
        state_nxt = S_SH_TADD;
      end

      S_SH_TADD: begin
        ctl.op    = spk_pkg::OP_QADD;
        ctl.pos   = tsec_r ? 2'd3 : 2'd2;
        unit_data = spk_pkg::low_bytes(rd_data, tail_n);
        if (rem_r > 5'd8 && !tsec_r) begin
          tsec_nxt  = 1'b1;
          p_nxt     = p_r + 5'd1;
          rem_nxt   = rem_r - 5'd8;
          state_nxt = S_SH_TRD;
        end else begin
          step_nxt  = 4'd0;
          state_nxt = S_SH_QEND;
        end
      end

      S_SH_QEND: begin
        ctl.op   = spk_pkg::OP_QEND;
        step_nxt = step_r + 4'd1;
        if (step_r == spk_pkg::QEND_LAST) begin
          step_nxt  = 4'd0;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          // short path ends with lanes rotated by three: a sits at 1, b at 2
          hash1_nxt     = long_r ? lanes_r[0] : lanes_r[1];
          hash2_nxt     = long_r ? lanes_r[1] : lanes_r[2];
          out_valid_nxt = 1'b1;
          long_nxt      = 1'b0;
          bs_nxt        = 8'd0;
          bwi_nxt       = 4'd0;
          fin_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 4'd0;
      rnd_r       <= 2'd0;
      seed1_r     <= 64'd0;
      seed2_r     <= 64'd0;
      bs_r        <= 8'd0;
      long_r      <= 1'b0;
      bwi_r       <= 4'd0;
      pend2_r     <= 1'b0;
      hi_r        <= 1'b0;
      fin_r       <= 1'b0;
      half_r      <= 1'b0;
      sub_r       <= 2'd0;
      tsec_r      <= 1'b0;
      bcnt_r      <= 3'd0;
      rem_r       <= 5'd0;
      p_r         <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      rnd_r       <= rnd_nxt;
      seed1_r     <= seed1_nxt;
      seed2_r     <= seed2_nxt;
      bs_r        <= bs_nxt;
      long_r      <= long_nxt;
      bwi_r       <= bwi_nxt;
      pend2_r     <= pend2_nxt;
      hi_r        <= hi_nxt;
      fin_r       <= fin_nxt;
      half_r      <= half_nxt;
      sub_r       <= sub_nxt;
      tsec_r      <= tsec_nxt;
      bcnt_r      <= bcnt_nxt;
      rem_r       <= rem_nxt;
      p_r         <= p_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lanes_r <= lanes_nxt;
    hash1_r <= hash1_nxt;
    hash2_r <= hash2_nxt;
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= spk_pkg::LAST_STEP)
    else $error("step counter out of range");

  a_long_fill: assert property (@(posedge clk) disable iff (!rst_n)
    long_r |-> (bs_r <= 8'd96 && bwi_r <= 4'd12))
    else $error("long block fill out of range");

  a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !long_r) |-> bs_r < spk_pkg::SHORT_LIMIT)
    else $error("short message overran the buffer");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_chan.ready)) |=>
      (out_valid_r && state_r == S_IDLE))
    else $error("result not presented after completion");

  a_idle_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!pend2_r && !hi_r))
    else $error("block mix left unfinished");

endmodule

>>> hw/rtl/spk_msg_buf.sv
// Message word store, 24 x 64, one write and one registered read per cycle.
// Depends on spk_pkg.
module spk_msg_buf (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [spk_pkg::BUF_AW-1:0] wr_addr,
  input  logic [63:0]                wr_data,
  input  logic [spk_pkg::BUF_AW-1:0] rd_addr,
  output logic [63:0]                rd_data
);
  logic [63:0] mem [spk_pkg::BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

>>> hw/rtl/spk_round_unit.sv
// Shared mixing unit: one step of lane mix, absorb, end round, quad mix, quad end or quad add per cycle.
// Lanes are kept rotated so each step works on fixed positions. Depends on spk_pkg.
module spk_round_unit (
  input  spk_pkg::spk_ctl_t   ctl,
  input  spk_pkg::spk_lanes_t lanes,
  input  logic [63:0]         data,
  output spk_pkg::spk_lanes_t lanes_out
);
  spk_pkg::spk_lanes_t tmp;
  logic [63:0] s0a, t11, a, x;

  always_comb begin
    tmp       = lanes;
    lanes_out = lanes;
    s0a = lanes[0] + data;
    t11 = '0;
    a   = '0;
    x   = '0;
    case (ctl.op)
      spk_pkg::OP_LMIX: begin
        tmp[0]  = spk_pkg::rotl(s0a, spk_pkg::MIX_ROT[ctl.step]);
        tmp[2]  = lanes[2] ^ lanes[10];
        tmp[11] = (lanes[11] ^ s0a) + lanes[1];
        lanes_out = {tmp[0], tmp[11:1]};
      end
      spk_pkg::OP_ABSORB: begin
        tmp[0] = s0a;
        lanes_out = {tmp[0], tmp[11:1]};
      end
      spk_pkg::OP_ENDR: begin
        t11     = lanes[11] + lanes[1];
        tmp[11] = t11;
        tmp[2]  = lanes[2] ^ t11;
        tmp[1]  = spk_pkg::rotl(lanes[1], spk_pkg::ENDR_ROT[ctl.step]);
        lanes_out = {tmp[0], tmp[11:1]};
      end
      spk_pkg::OP_QMIX: begin
        a      = spk_pkg::rotl(lanes[2], spk_pkg::QMIX_ROT[ctl.step]) + lanes[3];
        tmp[2] = a;
        tmp[0] = lanes[0] ^ a;
        lanes_out[3:0] = {tmp[0], tmp[3:1]};
      end
      spk_pkg::OP_QEND: begin
        x      = spk_pkg::rotl(lanes[2], spk_pkg::QEND_ROT[ctl.step]);
        tmp[3] = (lanes[3] ^ lanes[2]) + x;
        tmp[2] = x;
        lanes_out[3:0] = {tmp[0], tmp[3:1]};
      end
      spk_pkg::OP_QADD: begin
        lanes_out[ctl.pos] = lanes[ctl.pos] + data;
      end
      default: begin
        lanes_out = lanes;
      end
    endcase
  end
endmodule

>>> tb/spk_tb_ifs.sv
`timescale 1ns / 100ps
// Bench-side item types: one message word as driven and one expected hash pair.
// Depends on nothing.
package spk_tb_types;
  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } msg_word_t;
  typedef struct {
    logic [63:0] h1;
    logic [63:0] h2;
  } hash_pair_t;
endpackage

>>> tb/spooky_hash_128_stream_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for spooky_hash_128_stream: streams directed and random-length messages,
// predicts each 128-bit hash in the bench and compares it with every out_chan transfer.
// Depends on spk_pkg, spk_ifs.sv (channel interfaces) and spk_tb_types.
module spooky_hash_128_stream_tb;

  localparam int unsigned IDLE_LIMIT = 20000;

  logic clk;
  logic rst_n;

  spk_in_if  in_chan ();
  spk_out_if out_chan ();
  spk_cfg_if cfg_chan ();

  spooky_hash_128_stream i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------- hash predictor state ----------------
  logic [63:0] seed_a, seed_b;
  logic [63:0] lanes [12];
  logic [63:0] store [24];
  int unsigned nbytes_acc;
  bit          in_long;
  int unsigned blk_idx;

  spk_tb_types::msg_word_t  word_q [$];
  spk_tb_types::hash_pair_t hash_q [$];

  int unsigned errors;
  int unsigned idle_cycles;
  bit          quiet;       // stretch with no idling on either side

  function automatic logic [63:0] rol(logic [63:0] x, int unsigned k);
    k = k % 64;
    return (k == 0) ? x : ((x << k) | (x >> (64 - k)));
  endfunction

  function automatic logic [63:0] keep_bytes(logic [63:0] w, int unsigned n);
    if (n >= 8) return w;
    if (n == 0) return 64'd0;
    return w & ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  function automatic logic [63:0] stored(int unsigned i);
    return (i < 24) ? store[i] : 64'd0;
  endfunction

  // 12-lane block mix over store[base..base+11]
  task automatic block_mix(int unsigned base);
    for (int i = 0; i < 12; i++) begin
      lanes[i] += store[base + i];
      lanes[(i + 2) % 12] ^= lanes[(i + 10) % 12];
      lanes[(i + 11) % 12] ^= lanes[i];
      lanes[i] = rol(lanes[i], spk_pkg::MIX_ROT[i]);
      lanes[(i + 11) % 12] += lanes[(i + 1) % 12];
    end
  endtask

  task automatic end_rounds();
    for (int r = 0; r < 3; r++)
      for (int i = 0; i < 12; i++) begin
        lanes[(i + 11) % 12] += lanes[(i + 1) % 12];
        lanes[(i + 2) % 12] ^= lanes[(i + 11) % 12];
        lanes[(i + 1) % 12] = rol(lanes[(i + 1) % 12], spk_pkg::ENDR_ROT[i]);
      end
  endtask

  function automatic void four_mix(ref logic [63:0] h [4]);
    for (int j = 0; j < 12; j++) begin
      h[(j + 2) % 4] = rol(h[(j + 2) % 4], spk_pkg::QMIX_ROT[j]);
      h[(j + 2) % 4] += h[(j + 3) % 4];
      h[j % 4] ^= h[(j + 2) % 4];
    end
  endfunction

  function automatic void four_end(ref logic [63:0] h [4]);
    for (int j = 0; j < 11; j++) begin
      h[(j + 3) % 4] ^= h[(j + 2) % 4];
      h[(j + 2) % 4] = rol(h[(j + 2) % 4], spk_pkg::QEND_ROT[j]);
      h[(j + 3) % 4] += h[(j + 2) % 4];
    end
  endfunction

  function automatic spk_tb_types::hash_pair_t short_digest(int unsigned len);
    logic [63:0] h [4];
    int unsigned p, remain;
    spk_tb_types::hash_pair_t r;
    p = 0;
    remain = len % 32;
    h[0] = seed_a; h[1] = seed_b; h[2] = spk_pkg::SC_CONST; h[3] = spk_pkg::SC_CONST;
    if (len > 15) begin
      for (int k = 0; k < len / 32; k++) begin
        h[2] += stored(p); h[3] += stored(p + 1);
        four_mix(h);
        h[0] += stored(p + 2); h[1] += stored(p + 3);
        p += 4;
      end
      if (remain >= 16) begin
        h[2] += stored(p); h[3] += stored(p + 1);
        four_mix(h);
        p += 2;
        remain -= 16;
      end
    end
    h[3] += 64'(len & 8'hFF) << 56;
    if (remain == 0) begin
      h[2] += spk_pkg::SC_CONST; h[3] += spk_pkg::SC_CONST;
    end else begin
      h[2] += keep_bytes(stored(p), remain);
      if (remain > 8) h[3] += keep_bytes(stored(p + 1), remain - 8);
    end
    four_end(h);
    r.h1 = h[0];
    r.h2 = h[1];
    return r;
  endfunction

  // Advance the predictor by one accepted word; queue a hash when one is due.
  task automatic absorb_word(spk_tb_types::msg_word_t it);
    int unsigned n;
    logic [63:0] w;
    logic [63:0] pad [12];
    spk_tb_types::hash_pair_t r;
    n = 8;
    if (it.last) n = (it.nbytes > 8) ? 8 : it.nbytes;
    w = keep_bytes(it.word, n);
    if (!in_long) begin
      if (n > 0) begin
        if (nbytes_acc / 8 < 24) store[nbytes_acc / 8] = w;
        nbytes_acc += n;
      end
      if (nbytes_acc >= 192) begin
        for (int i = 0; i < 12; i += 3) begin
          lanes[i] = seed_a; lanes[i + 1] = seed_b; lanes[i + 2] = spk_pkg::SC_CONST;
        end
        block_mix(0);
        block_mix(12);
        in_long = 1'b1;
        nbytes_acc = 0;
        blk_idx = 0;
      end else begin
        if (it.last) begin
          hash_q.push_back(short_digest(nbytes_acc));
          nbytes_acc = 0;
          blk_idx = 0;
        end
        return;
      end
    end else if (n > 0) begin
      if (blk_idx < 12) store[blk_idx] = w;
      blk_idx++;
      nbytes_acc += n;
      if (blk_idx >= 12 && n == 8) begin
        block_mix(0);
        blk_idx = 0;
        nbytes_acc = 0;
      end
    end
    if (!it.last) return;
    // final block: zero pad, byte count in the top byte
    for (int i = 0; i < 12; i++) pad[i] = (i < blk_idx) ? store[i] : 64'd0;
    pad[11] = {8'(nbytes_acc & 8'hFF), pad[11][55:0]};
    for (int i = 0; i < 12; i++) lanes[i] += pad[i];
    end_rounds();
    r.h1 = lanes[0];
    r.h2 = lanes[1];
    hash_q.push_back(r);
    in_long = 1'b0;
    nbytes_acc = 0;
    blk_idx = 0;
  endtask

  // ---------------- stimulus building ----------------
  // Queues one message of len bytes; tail_nb overrides bytes_valid on the final word
  // (used for the zero and over-eight cases); empty message gives a single zero-byte word.
  task automatic queue_msg(int unsigned len, int tail_nb = -1, bit ones = 0);
    spk_tb_types::msg_word_t it;
    int unsigned left;
    left = len;
    do begin
      it.word = ones ? '1 : {$urandom, $urandom};
      it.last = (left <= 8);
      it.nbytes = it.last ? 4'(left) : 4'($urandom_range(0, 15));
      if (it.last && tail_nb >= 0) it.nbytes = 4'(tail_nb);
      word_q.push_back(it);
      left = (left > 8) ? left - 8 : 0;
    end while (!it.last);
  endtask

  function automatic int unsigned random_len();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return $urandom_range(0, 191);
    if (sel < 60) return $urandom_range(184, 200);
    if (sel < 85) return $urandom_range(193, 480);
    return $urandom_range(480, 900);
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      // previous transfer done (or none pending): pick the next word or idle
      if (word_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
        in_chan.valid       <= 1'b1;
        in_chan.data_word   <= word_q[0].word;
        in_chan.bytes_valid <= word_q[0].nbytes;
        in_chan.last_word   <= word_q[0].last;
        void'(word_q.pop_front());
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else        out_chan.ready <= quiet || ($urandom_range(0, 99) >= 9);
  end

  // ---------------- monitor ----------------
  spk_tb_types::msg_word_t seen;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        seen.word = in_chan.data_word;
        seen.nbytes = in_chan.bytes_valid;
        seen.last = in_chan.last_word;
        absorb_word(seen);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (hash_q.size() == 0) begin
          $display("%0t: hash transfer with none expected: %h %h", $time,
                   out_chan.hash_first, out_chan.hash_second);
          errors++;
        end else begin
          if (out_chan.hash_first !== hash_q[0].h1) begin
            $display("%0t: hash_first expected %h actual %h", $time, hash_q[0].h1,
                     out_chan.hash_first);
            errors++;
          end
          if (out_chan.hash_second !== hash_q[0].h2) begin
            $display("%0t: hash_second expected %h actual %h", $time, hash_q[0].h2,
                     out_chan.hash_second);
            errors++;
          end
          void'(hash_q.pop_front());
        end
      end
      // watchdog: cycles with no transfer on any channel
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
          || (cfg_chan.valid && cfg_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------- configuration ----------------
  task automatic write_seed(logic [7:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    // transfer happened at this edge
    if (idx == spk_pkg::REG_SEED_FIRST) seed_a = val;
    else if (idx == spk_pkg::REG_SEED_SECOND) seed_b = val;
    cfg_chan.valid <= 1'b0;
  endtask

  // let the block drain before touching seeds
  task automatic wait_drained();
    while (word_q.size() > 0 || in_chan.valid || hash_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_phase(int unsigned n_words);
    int unsigned target;
    target = word_q.size() + n_words;
    while (word_q.size() < target) queue_msg(random_len());
  endtask

  // ---------------- main sequence ----------------
  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    errors = 0;
    idle_cycles = 0;
    seed_a = '0; seed_b = '0;
    nbytes_acc = 0; in_long = 1'b0; blk_idx = 0;
    foreach (lanes[i]) lanes[i] = '0;
    foreach (store[i]) store[i] = '0;
    in_chan.valid = 1'b0;
    in_chan.data_word = '0;
    in_chan.bytes_valid = '0;
    in_chan.last_word = 1'b0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = '0;
    cfg_chan.data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset seeds, then short/long edges, tail byte counts
    queue_msg(0);                 // empty message
    queue_msg(8, 0);              // last word with zero valid bytes
    queue_msg(5, 13, 1);          // bytes_valid above eight saturates
    queue_msg(15, -1, 1);
    queue_msg(16);
    queue_msg(31);
    queue_msg(32);
    queue_msg(48, -1, 1);
    queue_msg(191);
    queue_msg(192);               // switch to long path on the last word
    queue_msg(200);
    queue_msg(288);               // exactly one extra whole block
    wait_drained();

    write_seed(spk_pkg::REG_SEED_FIRST, '1);
    write_seed(spk_pkg::REG_SEED_SECOND, '1);
    write_seed(8'd7, {$urandom, $urandom});   // unlisted index is ignored
    queue_msg(0);
    queue_msg(100, -1, 1);
    queue_msg(300);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_seed(spk_pkg::REG_SEED_FIRST, {$urandom, $urandom});
      write_seed(spk_pkg::REG_SEED_SECOND, (ph == 3) ? 64'd0 : {$urandom, $urandom});
      quiet = (ph == 2);
      random_phase(220);
      wait_drained();
    end
    quiet = 1'b0;

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
